/* hdl/dcsp_pkg.sv */
// Shared types and constants for the decimal currency string parser.
package dcsp_pkg;

  // Width of the whole-part accumulator (holds up to AMOUNT_MAX / 100)
  localparam int unsigned WholeW  = 57;
  // Width of the scaled fractional part (0 to 99)
  localparam int unsigned FracW   = 7;
  // Width of the result amount
  localparam int unsigned AmountW = 63;

  localparam logic [AmountW-1:0] AmountMax  = {AmountW{1'b1}};
  localparam logic [WholeW-1:0]  WholeLimit = WholeW'(AmountMax / 100);

  // Character codes
  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  // Fractional digit counts
  localparam logic [1:0] FracOneDigit = 2'd1;

  // One input item as held in the input register
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
    logic       no_char;
  } item_t;

  // Parse state at the end of a string, handed to the total stage
  typedef struct packed {
    logic              ok;
    logic [WholeW-1:0] whole;
    logic [FracW-1:0]  frac;
  } snap_t;

  // Final result item
  typedef struct packed {
    logic [AmountW-1:0] amount;
    logic               valid_res;
  } result_t;

endpackage

/* hdl/dcsp_scan.sv */
// Character scanner: parse state registers and per-character update logic.
module dcsp_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  dcsp_pkg::item_t  item_i,
  output dcsp_pkg::snap_t  snap_o
);

  logic [dcsp_pkg::WholeW-1:0] whole_q, whole_d;
  logic                        seen_q, seen_d;
  logic                        dot_q, dot_d;
  logic [1:0]                  fcnt_q, fcnt_d;
  logic [dcsp_pkg::FracW-1:0]  fval_q, fval_d;
  logic                        failed_q, failed_d;

  logic                        is_digit;
  logic [3:0]                  digit;
  logic [dcsp_pkg::WholeW+3:0] acc_mul;
  logic [dcsp_pkg::FracW-1:0]  frac_mul;

  // Digit decode
  assign is_digit = (item_i.char_code >= dcsp_pkg::CharZero) &&
                    (item_i.char_code <= dcsp_pkg::CharNine);
  assign digit    = is_digit ? 4'(item_i.char_code - dcsp_pkg::CharZero) : 4'd0;

  // whole * 10 + digit; never exceeds ten times the limit plus nine
  assign acc_mul  = ((dcsp_pkg::WholeW+4)'(whole_q) << 3) +
                    ((dcsp_pkg::WholeW+4)'(whole_q) << 1) +
                    (dcsp_pkg::WholeW+4)'(digit);
  // frac * 10 + digit; frac is a single digit whenever this is used
  assign frac_mul = (fval_q << 3) + (fval_q << 1) + dcsp_pkg::FracW'(digit);

  // Next parse state for the item in the input register
  always_comb begin
    whole_d  = whole_q;
    seen_d   = seen_q;
    dot_d    = dot_q;
    fcnt_d   = fcnt_q;
    fval_d   = fval_q;
    failed_d = failed_q;
    if (!item_i.no_char && !failed_q) begin
      if (!dot_q) begin
        if (item_i.char_code == dcsp_pkg::CharDot) begin
          dot_d = 1'b1;
        end else if (is_digit) begin
          if (acc_mul > (dcsp_pkg::WholeW+4)'(dcsp_pkg::WholeLimit)) begin
            failed_d = 1'b1;
          end else begin
            whole_d = acc_mul[dcsp_pkg::WholeW-1:0];
            seen_d  = 1'b1;
          end
        end else begin
          failed_d = 1'b1;
        end
      end else if (!is_digit || fcnt_q[1]) begin
        failed_d = 1'b1;
      end else begin
        fval_d = frac_mul;
        fcnt_d = fcnt_q + 2'd1;
      end
    end
  end

  // End-of-string view: format check and fraction scaled to hundredths
  always_comb begin
    snap_o.ok    = !failed_d && seen_d && !(dot_d && (fcnt_d == 2'd0));
    snap_o.whole = whole_d;
    snap_o.frac  = (fcnt_d == dcsp_pkg::FracOneDigit) ?
                   dcsp_pkg::FracW'((fval_d << 3) + (fval_d << 1)) : fval_d;
  end

  // State registers; cleared after the last item of a string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      whole_q  <= '0;
      seen_q   <= 1'b0;
      dot_q    <= 1'b0;
      fcnt_q   <= '0;
      fval_q   <= '0;
      failed_q <= 1'b0;
    end else if (adv_i) begin
      if (item_i.is_last) begin
        whole_q  <= '0;
        seen_q   <= 1'b0;
        dot_q    <= 1'b0;
        fcnt_q   <= '0;
        fval_q   <= '0;
        failed_q <= 1'b0;
      end else begin
        whole_q  <= whole_d;
        seen_q   <= seen_d;
        dot_q    <= dot_d;
        fcnt_q   <= fcnt_d;
        fval_q   <= fval_d;
        failed_q <= failed_d;
      end
    end
  end

endmodule

/* hdl/dcsp_total.sv */
// Total stage: whole * 100 + fraction with range check.
module dcsp_total (
  input  dcsp_pkg::snap_t   snap_i,
  output dcsp_pkg::result_t res_o
);

  logic [dcsp_pkg::AmountW:0] total;
  logic                       in_range;

  // 100 = 64 + 32 + 4
  assign total = ((dcsp_pkg::AmountW+1)'(snap_i.whole) << 6) +
                 ((dcsp_pkg::AmountW+1)'(snap_i.whole) << 5) +
                 ((dcsp_pkg::AmountW+1)'(snap_i.whole) << 2) +
                 (dcsp_pkg::AmountW+1)'(snap_i.frac);

  assign in_range = (total <= (dcsp_pkg::AmountW+1)'(dcsp_pkg::AmountMax));

  always_comb begin
    res_o.valid_res = snap_i.ok && in_range;
    res_o.amount    = res_o.valid_res ? total[dcsp_pkg::AmountW-1:0] : '0;
  end

endmodule

/* hdl/decimal_currency_string_parser.sv */
// Decimal currency string parser: one ASCII character per item, amount in hundredths.
// The last character's result passes the snapshot and then the result register.
// Throughput: one character per cycle unless stalled; each updates the parse state.
// Stall on the output backs up through the registered stages only when all are full.
// Reset (rst_ni low, asynchronous): pipeline empties and the parse state is cleared.
module decimal_currency_string_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        is_last_i,
  input  logic        no_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [62:0] amount_hundredths_o,
  output logic        valid_res_o
);

  dcsp_pkg::item_t   item_q;
  dcsp_pkg::snap_t   snap_d, snap_q;
  dcsp_pkg::result_t res_d, res_q;
  logic              v1_q, v2_q, v3_q;
  logic              load3, free2, adv1, adv2, in_fire;

  // Stage flow control
  assign load3      = !v3_q || !out_stall_i;
  assign adv2       = v2_q && load3;
  assign free2      = !v2_q || load3;
  assign adv1       = v1_q && free2;
  assign in_stall_o = v1_q && !free2;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (!in_stall_o) v1_q <= in_valid_i;
      if (free2)       v2_q <= adv1 && item_q.is_last;
      if (load3)       v3_q <= v2_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.char_code <= char_code_i;
      item_q.is_last   <= is_last_i;
      item_q.no_char   <= no_char_i;
    end
  end

  dcsp_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv1),
    .item_i (item_q),
    .snap_o (snap_d)
  );

  // Snapshot register, loaded on the last item of a string
  always_ff @(posedge clk_i) begin
    if (adv1 && item_q.is_last) snap_q <= snap_d;
  end

  dcsp_total u_total (
    .snap_i (snap_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv2) res_q <= res_d;
  end

  assign out_valid_o         = v3_q;
  assign amount_hundredths_o = res_q.amount;
  assign valid_res_o         = res_q.valid_res;

endmodule
